// File: design/lpd_pkg.sv
// Shared types, register indexes and status codes for the log packet deframer.
package lpd_pkg;

  // Shortest buffer that can hold header, timestamp, millis, type, action,
  // length and tail with an empty payload.
  localparam int MIN_PACKET_BYTES = 2 + 4 + 2 + 1 + 1 + 1 + 1;

  localparam int POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] PAYLOAD_START = POS_W'(MIN_PACKET_BYTES - 1);

  // Configuration register indexes (byte address / 4).
  localparam int CFG_ADDR_W = 4;
  localparam logic [1:0] REG_HEADER_WORD = 2'd0;
  localparam logic [1:0] REG_TAIL_VALUE  = 2'd1;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

  localparam logic [15:0] HEADER_WORD_RST = 16'hAA55;
  localparam logic [7:0]  TAIL_VALUE_RST  = 8'h55;
  localparam logic [7:0]  MAX_PAYLOAD_RST = 8'd64;

  // Report status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_HEADER = 3'd2;
  localparam logic [2:0] ST_LEN_OVER   = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;
  localparam logic [2:0] ST_BAD_TAIL   = 3'd5;

  typedef struct packed {
    logic [15:0] header_word;
    logic [7:0]  tail_value;
    logic [7:0]  max_payload;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [2:0]  status;
    logic [31:0] stamp_seconds;
    logic [15:0] stamp_millis;
    logic [7:0]  packet_type;
    logic [7:0]  packet_action;
    logic [7:0]  payload_length;
    logic        last_of_run;
  } result_t;

endpackage

// File: design/lpd_if.sv
// Valid/ready channel interfaces for the deframer input and result words.
interface lpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, in_byte, end_of_buffer, input ready);
  modport sink   (input valid, in_byte, end_of_buffer, output ready);
endinterface

interface lpd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [2:0]  status;
  logic [31:0] stamp_seconds;
  logic [15:0] stamp_millis;
  logic [7:0]  packet_type;
  logic [7:0]  packet_action;
  logic [7:0]  payload_length;
  logic        last_of_run;

  modport source (output valid, kind, payload_byte, payload_index, status, stamp_seconds,
                  stamp_millis, packet_type, packet_action, payload_length, last_of_run,
                  input ready);
  modport sink   (input valid, kind, payload_byte, payload_index, status, stamp_seconds,
                  stamp_millis, packet_type, packet_action, payload_length, last_of_run,
                  output ready);
endinterface

// File: design/log_packet_deframer_top.sv
// Top level of the log packet deframer: input register, frame tracker, result register.
//
// The deframer takes one received byte per input word, with a flag on the last byte of
// the buffer, and walks the log packet layout: a 16-bit header (low byte first), a
// 32-bit little-endian timestamp, a 16-bit millisecond count, type, action, a length
// byte, the payload and a tail byte. Payload bytes come out as payload words while the
// header and length checks stand clean; the last byte of the buffer gives one report
// word with the captured fields and a status (ok, too short, bad header, length over
// maximum, truncated, bad tail). A word runs through an input register, a single stage
// of position compares and field captures, and a result register, so the block takes
// one word every clock cycle while the receiver keeps up. A result is valid on the
// output once the frame stage has moved its byte from the input register into the
// result register. While a result waits, the input register still takes one more
// byte; once both registers are full, the input ready follows the output ready within
// the same cycle. Words that cause no result, such as header bytes and bytes after the
// tail, only update the tracked state, but they also wait behind a result that has
// not been taken.
// The three configuration registers sit at byte addresses 0, 4 and 8 and should be
// written while no byte is in flight. There is no clearing pass after reset.
module log_packet_deframer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  lpd_in_if.sink                           in_word,
  lpd_out_if.source                        out_word,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lpd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import lpd_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  // Input register holding one accepted word until the frame stage takes it.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Result register.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic advance;
  logic in_take;

  // The frame stage fires when a word is held and the result register is free or
  // being emptied in this same cycle.
  assign advance = s1_valid_r && (!out_valid_r || out_word.ready);
  assign in_word.ready = !s1_valid_r || advance;
  assign in_take = in_word.valid && in_word.ready;

  lpd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lpd_frame u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .b         (s1_byte_r),
    .last      (s1_last_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_comb begin
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_word.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_word.in_byte;
      s1_last_r <= in_word.end_of_buffer;
    end
    if (advance && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_word.valid          = out_valid_r;
  assign out_word.kind           = out_res_r.kind;
  assign out_word.payload_byte   = out_res_r.payload_byte;
  assign out_word.payload_index  = out_res_r.payload_index;
  assign out_word.status         = out_res_r.status;
  assign out_word.stamp_seconds  = out_res_r.stamp_seconds;
  assign out_word.stamp_millis   = out_res_r.stamp_millis;
  assign out_word.packet_type    = out_res_r.packet_type;
  assign out_word.packet_action  = out_res_r.packet_action;
  assign out_word.payload_length = out_res_r.payload_length;
  assign out_word.last_of_run    = out_res_r.last_of_run;

  // The last byte of a buffer always produces a report in the next cycle.
  a_last_gives_report: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_last_r) |=> (out_valid_r && out_res_r.kind && out_res_r.last_of_run))
    else $error("last byte did not produce a report word");

  // A payload word carries a clean status and is never marked as the end of a run.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.kind) |-> (out_res_r.status == ST_OK && !out_res_r.last_of_run))
    else $error("payload word with report fields set");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.status <= ST_BAD_TAIL))
    else $error("status code out of range");

  // A held word that cannot advance keeps the input stalled.
  a_hold_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_word.ready) |=> s1_valid_r)
    else $error("input register lost a word while the output was stalled");

endmodule

// File: design/lpd_cfg_regs.sv
// APB-style configuration registers of the log packet deframer.
module lpd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lpd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output lpd_pkg::cfg_t                     cfg
);
  import lpd_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        REG_HEADER_WORD: cfg_nxt.header_word = pwdata[15:0];
        REG_TAIL_VALUE:  cfg_nxt.tail_value  = pwdata[7:0];
        REG_MAX_PAYLOAD: cfg_nxt.max_payload = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_HEADER_WORD: prdata = {16'd0, cfg_r.header_word};
      REG_TAIL_VALUE:  prdata = {24'd0, cfg_r.tail_value};
      REG_MAX_PAYLOAD: prdata = {24'd0, cfg_r.max_payload};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_word <= HEADER_WORD_RST;
      cfg_r.tail_value  <= TAIL_VALUE_RST;
      cfg_r.max_payload <= MAX_PAYLOAD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/lpd_frame.sv
// Frame tracker: byte position, captured header fields and the result of one byte.
module lpd_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       b,
  input  logic             last,
  input  lpd_pkg::cfg_t    cfg,
  output logic             res_valid,
  output lpd_pkg::result_t res
);
  import lpd_pkg::*;

  localparam logic [POS_W-1:0] POS_HDR_LO = 9'd0;
  localparam logic [POS_W-1:0] POS_HDR_HI = 9'd1;
  localparam logic [POS_W-1:0] POS_SEC_0  = 9'd2;
  localparam logic [POS_W-1:0] POS_SEC_1  = 9'd3;
  localparam logic [POS_W-1:0] POS_SEC_2  = 9'd4;
  localparam logic [POS_W-1:0] POS_SEC_3  = 9'd5;
  localparam logic [POS_W-1:0] POS_MS_LO  = 9'd6;
  localparam logic [POS_W-1:0] POS_MS_HI  = 9'd7;
  localparam logic [POS_W-1:0] POS_TYPE   = 9'd8;
  localparam logic [POS_W-1:0] POS_ACTION = 9'd9;
  localparam logic [POS_W-1:0] POS_LENGTH = 9'd10;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       fhb_r, fhb_nxt;
  logic [31:0]      sec_r, sec_nxt;
  logic [15:0]      ms_r, ms_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       action_r, action_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [2:0]       err_r, err_nxt;
  logic             tc_r, tc_nxt;
  logic [POS_W-1:0] tail_pos;
  logic [POS_W-1:0] pay_off;
  logic [1:0]       lane;

  assign tail_pos = PAYLOAD_START + {1'b0, len_r};
  assign pay_off  = pos_r - PAYLOAD_START;
  // Positions 2..5 map onto byte lanes 0..3 of the timestamp.
  assign lane     = pos_r[1:0] ^ 2'b10;

  always_comb begin
    fhb_nxt    = fhb_r;
    sec_nxt    = sec_r;
    ms_nxt     = ms_r;
    type_nxt   = type_r;
    action_nxt = action_r;
    len_nxt    = len_r;
    err_nxt    = err_r;
    tc_nxt     = tc_r;
    res_valid  = 1'b0;
    res        = '0;

    case (pos_r)
      POS_HDR_LO: fhb_nxt = b;
      POS_HDR_HI: begin
        if ({b, fhb_r} != cfg.header_word && err_r == ST_OK) err_nxt = ST_BAD_HEADER;
      end
      POS_SEC_0, POS_SEC_1, POS_SEC_2, POS_SEC_3: begin
        sec_nxt[8*lane +: 8] = sec_r[8*lane +: 8] | b;
      end
      POS_MS_LO:  ms_nxt[7:0]  = b;
      POS_MS_HI:  ms_nxt[15:8] = b;
      POS_TYPE:   type_nxt     = b;
      POS_ACTION: action_nxt   = b;
      POS_LENGTH: begin
        len_nxt = b;
        if (b > cfg.max_payload && err_r == ST_OK) err_nxt = ST_LEN_OVER;
      end
      default: begin
        if (pos_r < tail_pos) begin
          if (err_r == ST_OK && !last) begin
            res_valid         = 1'b1;
            res.payload_byte  = b;
            res.payload_index = pay_off[7:0];
          end
        end else if (pos_r == tail_pos && !tc_r) begin
          tc_nxt = 1'b1;
          if (b != cfg.tail_value && err_r == ST_OK) err_nxt = ST_BAD_TAIL;
        end
      end
    endcase

    if (last) begin
      res_valid          = 1'b1;
      res                = '0;
      res.kind           = 1'b1;
      res.last_of_run    = 1'b1;
      res.stamp_seconds  = sec_nxt;
      res.stamp_millis   = ms_nxt;
      res.packet_type    = type_nxt;
      res.packet_action  = action_nxt;
      res.payload_length = len_nxt;
      if (pos_r < PAYLOAD_START) begin
        res.status = ST_TOO_SHORT;
      end else if (err_nxt != ST_OK) begin
        res.status = err_nxt;
      end else if (!tc_nxt) begin
        res.status = ST_TRUNCATED;
      end else begin
        res.status = ST_OK;
      end
    end

    if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      fhb_r    <= '0;
      sec_r    <= '0;
      ms_r     <= '0;
      type_r   <= '0;
      action_r <= '0;
      len_r    <= '0;
      err_r    <= ST_OK;
      tc_r     <= 1'b0;
    end else if (step) begin
      if (last) begin
        pos_r    <= '0;
        fhb_r    <= '0;
        sec_r    <= '0;
        ms_r     <= '0;
        type_r   <= '0;
        action_r <= '0;
        len_r    <= '0;
        err_r    <= ST_OK;
        tc_r     <= 1'b0;
      end else begin
        pos_r    <= pos_nxt;
        fhb_r    <= fhb_nxt;
        sec_r    <= sec_nxt;
        ms_r     <= ms_nxt;
        type_r   <= type_nxt;
        action_r <= action_nxt;
        len_r    <= len_nxt;
        err_r    <= err_nxt;
        tc_r     <= tc_nxt;
      end
    end
  end

endmodule

// File: verif/lpd_tb_pkg.sv
// Scoreboard class for the log packet deframer: predicts result words and checks them.
`timescale 1ns / 1ps
package lpd_tb_pkg;
  import lpd_pkg::*;

  class deframer_scoreboard;
    // Register copies, written when the bench writes the block's registers.
    logic [15:0] header_word = HEADER_WORD_RST;
    logic [7:0]  tail_value  = TAIL_VALUE_RST;
    logic [7:0]  max_payload = MAX_PAYLOAD_RST;

    // Frame tracking state.
    logic [POS_W-1:0] position;
    logic [7:0]  first_byte;
    logic [31:0] seconds;
    logic [15:0] millis;
    logic [7:0]  pkt_type;
    logic [7:0]  pkt_action;
    logic [7:0]  pkt_length;
    logic [2:0]  error_code;
    bit          tail_seen;

    result_t     expected_words[$];
    int unsigned mismatches;

    function new();
      clear_frame();
      mismatches = 0;
    endfunction

    function void clear_frame();
      position   = '0;
      first_byte = '0;
      seconds    = '0;
      millis     = '0;
      pkt_type   = '0;
      pkt_action = '0;
      pkt_length = '0;
      error_code = ST_OK;
      tail_seen  = 1'b0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_HEADER_WORD: header_word = value[15:0];
        REG_TAIL_VALUE:  tail_value  = value[7:0];
        REG_MAX_PAYLOAD: max_payload = value[7:0];
        default: ;
      endcase
    endfunction

    // Walks one accepted byte through the packet layout and queues what it causes.
    function void note_byte(logic [7:0] b, logic eob);
      result_t word;
      int      pos;
      int      tail_pos;
      pos  = int'(position);
      word = '0;
      if (pos == 0) begin
        first_byte = b;
      end else if (pos == 1) begin
        if ({b, first_byte} != header_word && error_code == ST_OK)
          error_code = ST_BAD_HEADER;
      end else if (pos <= 5) begin
        seconds[8*(pos-2) +: 8] = b;
      end else if (pos == 6) begin
        millis[7:0] = b;
      end else if (pos == 7) begin
        millis[15:8] = b;
      end else if (pos == 8) begin
        pkt_type = b;
      end else if (pos == 9) begin
        pkt_action = b;
      end else if (pos == 10) begin
        pkt_length = b;
        if (b > max_payload && error_code == ST_OK)
          error_code = ST_LEN_OVER;
      end else begin
        tail_pos = MIN_PACKET_BYTES - 1 + int'(pkt_length);
        if (pos < tail_pos) begin
          // A payload byte that also ends the buffer only yields the report.
          if (error_code == ST_OK && !eob) begin
            word.payload_byte  = b;
            word.payload_index = 8'(pos - (MIN_PACKET_BYTES - 1));
            expected_words.push_back(word);
          end
        end else if (pos == tail_pos && !tail_seen) begin
          tail_seen = 1'b1;
          if (b != tail_value && error_code == ST_OK)
            error_code = ST_BAD_TAIL;
        end
      end

      if (eob) begin
        word = '0;
        word.kind = 1'b1;
        if (pos + 1 < MIN_PACKET_BYTES)
          word.status = ST_TOO_SHORT;
        else if (error_code != ST_OK)
          word.status = error_code;
        else if (!tail_seen)
          word.status = ST_TRUNCATED;
        else
          word.status = ST_OK;
        word.stamp_seconds  = seconds;
        word.stamp_millis   = millis;
        word.packet_type    = pkt_type;
        word.packet_action  = pkt_action;
        word.payload_length = pkt_length;
        word.last_of_run    = 1'b1;
        expected_words.push_back(word);
        clear_frame();
      end else if (position != POS_MAX) begin
        position = position + 1'b1;
      end
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(result_t got);
      result_t want;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d status %0d", got.kind, got.status);
        mismatches++;
        return;
      end
      want = expected_words.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      compare_field("payload_index", 32'(want.payload_index), 32'(got.payload_index));
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("stamp_seconds", want.stamp_seconds, got.stamp_seconds);
      compare_field("stamp_millis", 32'(want.stamp_millis), 32'(got.stamp_millis));
      compare_field("packet_type", 32'(want.packet_type), 32'(got.packet_type));
      compare_field("packet_action", 32'(want.packet_action), 32'(got.packet_action));
      compare_field("payload_length", 32'(want.payload_length), 32'(got.payload_length));
      compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

endpackage

// File: verif/tb_log_packet_deframer_top.sv
// Top-level testbench for the log packet deframer: stimulus, handshakes and final verdict.
`timescale 1ns / 1ps
module tb_log_packet_deframer_top;
  import lpd_pkg::*;
  import lpd_tb_pkg::*;

  // The run is cut off here; the slowest legal run stays far below it.
  localparam int CYCLE_LIMIT    = 400000;
  // Cycles allowed after the last expected word before a register write or the verdict.
  // A byte passes only the input register and the result register once the output is
  // free, so this is ample.
  localparam int SETTLE_CYCLES  = 8;
  // Length of the long receiver hold-off that fills the block and stalls its input.
  localparam int HOLDOFF_CYCLES = 300;

  typedef enum int {
    FR_GOOD,
    FR_BAD_HEADER,
    FR_LEN_OVER,
    FR_TRUNCATED,
    FR_BAD_TAIL,
    FR_TOO_SHORT,
    FR_NOISE
  } frame_variant_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  lpd_in_if  in_word ();
  lpd_out_if out_word ();

  log_packet_deframer_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  deframer_scoreboard sb;

  int          sender_idle_pct;
  int          stall_pct;
  bit          holdoff_req;
  bit          holdoff_ack;
  int          holdoff_left;
  int unsigned cycle_count = 0;
  int unsigned cfg_mismatches;
  result_t     seen;

  // Bytes of the buffer being sent.
  logic [7:0]  frame_bytes[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver. It stalls at the current rate, and when the main sequence toggles
  // holdoff_req it keeps ready low for a long stretch counted here, so that the
  // block's registers fill up and the input side stalls.
  initial begin
    out_word.ready = 1'b0;
    holdoff_ack    = 1'b0;
    holdoff_left   = 0;
    forever begin
      @(posedge clk);
      if (holdoff_req != holdoff_ack) begin
        holdoff_ack  = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_word.ready <= 1'b0;
      end else begin
        out_word.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Every word taken by the bench at a rising edge is checked against the oldest
  // expectation. Signals are read right after the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && out_word.valid && out_word.ready) begin
      seen.kind           = out_word.kind;
      seen.payload_byte   = out_word.payload_byte;
      seen.payload_index  = out_word.payload_index;
      seen.status         = out_word.status;
      seen.stamp_seconds  = out_word.stamp_seconds;
      seen.stamp_millis   = out_word.stamp_millis;
      seen.packet_type    = out_word.packet_type;
      seen.packet_action  = out_word.packet_action;
      seen.payload_length = out_word.payload_length;
      seen.last_of_run    = out_word.last_of_run;
      sb.check_word(seen);
    end
  end

  // Offers one byte, possibly after some idle cycles, and returns once it is taken.
  // Valid stays high after acceptance so back-to-back words need no extra update.
  task automatic send_word(input logic [7:0] b, input logic eob);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_word.valid <= 1'b0;
      @(posedge clk);
    end
    in_word.valid         <= 1'b1;
    in_word.in_byte       <= b;
    in_word.end_of_buffer <= eob;
    @(posedge clk);
    while (!in_word.ready) @(posedge clk);
    sb.note_byte(b, eob);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_word(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  // Stops offering and waits until every expected word has come out, then lets the
  // block settle so that bytes with no result have left the pipeline as well.
  task automatic drain_results();
    in_word.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One configuration access: setup cycle, access cycle, then an idle cycle after it.
  task automatic apb_access(input logic [1:0] index, input logic write_en,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {index, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Writes a register and reads it back. Upper bits beyond the register are random
  // and must be dropped by the block.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] mask;
    apb_access(index, 1'b1, value, readback);
    sb.write_reg(index, value);
    apb_access(index, 1'b0, '0, readback);
    mask = (index == REG_HEADER_WORD) ? 32'h0000_FFFF : 32'h0000_00FF;
    if ((readback & mask) !== (value & mask)) begin
      $error("register %0d readback mismatch: expected 0x%0h, actual 0x%0h",
             index, value & mask, readback & mask);
      cfg_mismatches++;
    end
  endtask

  task automatic set_config(input logic [15:0] header, input logic [7:0] tail,
                            input logic [7:0] max_len);
    write_register(REG_HEADER_WORD, {16'($urandom), header});
    write_register(REG_TAIL_VALUE, {24'($urandom), tail});
    write_register(REG_MAX_PAYLOAD, {24'($urandom), max_len});
  endtask

  // Payload lengths are mostly short so that many buffers fit in the run.
  function automatic logic [7:0] pick_length();
    if (sb.max_payload == 8'd0) return 8'd0;
    if ($urandom_range(99) < 85)
      return 8'($urandom_range(0, (sb.max_payload < 8'd12) ? sb.max_payload : 12));
    return 8'($urandom_range(0, sb.max_payload));
  endfunction

  // Builds one buffer. Well-formed packets use the current header and tail; the
  // faulty kinds corrupt one part, sometimes several at once so that the earliest
  // error has to win. A nonzero pad_to asks for the longest payload and pads the
  // buffer with ignored bytes up to that size.
  function automatic void build_frame(input frame_variant_t variant, input int pad_to);
    logic [15:0] header;
    logic [7:0]  length;
    logic [7:0]  tail;
    int          cut;
    frame_bytes.delete();
    header = sb.header_word;
    tail   = sb.tail_value;
    length = (pad_to != 0) ? sb.max_payload : pick_length();
    if (variant == FR_LEN_OVER && sb.max_payload == 8'd255) variant = FR_BAD_TAIL;
    if (variant == FR_BAD_HEADER) begin
      header ^= 16'($urandom_range(1, 65535));
      if ($urandom_range(1) == 1) tail ^= 8'($urandom_range(1, 255));
    end
    if (variant == FR_LEN_OVER ||
        (variant == FR_BAD_HEADER && sb.max_payload != 8'd255 && $urandom_range(1) == 1))
      length = 8'($urandom_range(int'(sb.max_payload) + 1, 255));
    if (variant == FR_BAD_TAIL || (variant == FR_LEN_OVER && $urandom_range(1) == 1))
      tail ^= 8'($urandom_range(1, 255));
    if (variant == FR_TRUNCATED && length == 8'd0 && sb.max_payload != 8'd0) length = 8'd1;

    frame_bytes.push_back(header[7:0]);
    frame_bytes.push_back(header[15:8]);
    repeat (8) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(length);
    repeat (int'(length)) frame_bytes.push_back(8'($urandom));
    frame_bytes.push_back(tail);

    case (variant)
      FR_TRUNCATED: begin
        // Ends before the tail; with no payload possible it becomes a short buffer.
        if (length == 8'd0)
          cut = $urandom_range(1, MIN_PACKET_BYTES - 1);
        else
          cut = $urandom_range(MIN_PACKET_BYTES, MIN_PACKET_BYTES - 1 + int'(length));
      end
      FR_TOO_SHORT: cut = $urandom_range(1, MIN_PACKET_BYTES - 1);
      FR_LEN_OVER: begin
        cut = frame_bytes.size();
        if (cut > 40) cut = 40;
        cut = $urandom_range(MIN_PACKET_BYTES, cut);
      end
      default: cut = frame_bytes.size();
    endcase
    while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());

    if (variant == FR_NOISE) begin
      frame_bytes.delete();
      repeat ($urandom_range(1, 30)) frame_bytes.push_back(8'($urandom));
    end

    // Some good packets are followed by a few bytes that the block ignores.
    if (variant == FR_GOOD && pad_to == 0 && $urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() < pad_to) frame_bytes.push_back(8'($urandom));
  endfunction

  function automatic frame_variant_t pick_variant();
    int r;
    r = $urandom_range(99);
    if (r < 55) return FR_GOOD;
    if (r < 63) return FR_BAD_HEADER;
    if (r < 71) return FR_LEN_OVER;
    if (r < 79) return FR_TRUNCATED;
    if (r < 87) return FR_BAD_TAIL;
    if (r < 93) return FR_TOO_SHORT;
    return FR_NOISE;
  endfunction

  // One phase of random buffers at the given idle and stall rates, ending idle.
  task automatic run_phase(input int idle, input int stall, input int budget);
    int sent;
    sent            = 0;
    sender_idle_pct = idle;
    stall_pct      <= stall;
    while (sent < budget) begin
      build_frame(pick_variant(), 0);
      send_frame();
      sent += frame_bytes.size();
    end
    drain_results();
  endtask

  initial begin
    // Every input is known from time zero, while reset is held.
    rst_n                  = 1'b0;
    in_word.valid          = 1'b0;
    in_word.in_byte        = '0;
    in_word.end_of_buffer  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    sender_idle_pct        = 0;
    stall_pct              = 0;
    holdoff_req            = 1'b0;
    cfg_mismatches         = 0;
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed buffers with the reset register values. The first is a complete
    // packet whose timestamp, millis and type sit at all-ones, with a one-byte payload. Then a
    // single-byte buffer, and one that stops one byte short of the minimum, both of
    // which must report too short with whatever fields were captured.
    frame_bytes = '{8'h55, 8'hAA, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                    8'hFF, 8'h00, 8'h01, 8'h80, 8'h55};
    send_frame();
    frame_bytes = '{8'h00};
    send_frame();
    frame_bytes = '{8'h55, 8'hAA, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06,
                    8'h07, 8'h08, 8'h00};
    send_frame();
    drain_results();

    // Random phases, each under a different register setting and idle or stall pattern.
    run_phase(0, 0, 16);
    set_config(16'hFFFF, 8'h00, 8'd255);
    run_phase(66, 0, 16);
    set_config(16'h0000, 8'hFF, 8'd0);
    run_phase(0, 66, 16);
    set_config(16'($urandom), 8'($urandom), 8'($urandom_range(1, 40)));
    run_phase(9, 9, 16);

    // The receiver holds off for a long stretch while the sender keeps offering
    // well-formed packets, so the block backs up to its input. The sender then
    // pauses until every expected word has come out.
    set_config(16'($urandom), 8'($urandom), 8'd255);
    sender_idle_pct = 0;
    stall_pct      <= 0;
    holdoff_req    <= ~holdoff_req;
    repeat (2) begin
      build_frame(FR_GOOD, 0);
      send_frame();
    end
    drain_results();

    // A packet with the longest payload, padded with ignored bytes past the point
    // where the byte position saturates.
    build_frame(FR_GOOD, 520);
    send_frame();
    drain_results();

    run_phase(0, 0, 16);

    if (sb.mismatches == 0 && cfg_mismatches == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/lpd_pkg.sv
design/lpd_if.sv
design/lpd_cfg_regs.sv
design/lpd_frame.sv
design/log_packet_deframer_top.sv
verif/lpd_tb_pkg.sv
verif/tb_log_packet_deframer_top.sv
